@@ src/cmmr_pkg.sv @@
// Shared types and constants for the column min-max rescaler.
// No dependencies; imported by every module of the block except cmmr_ram.
package cmmr_pkg;

	localparam int COL_W    = 6;
	localparam int VAL_W    = 32;
	localparam int SCALED_W = 17;
	localparam int QUO_W    = 16;

	localparam logic [1:0] KIND_CLEAR   = 2'd0;
	localparam logic [1:0] KIND_OBSERVE = 2'd1;
	localparam logic [1:0] KIND_SCALE   = 2'd2;

	localparam logic signed [VAL_W-1:0] RESET_MIN = 32'sh7FFF_FFFF;
	localparam logic signed [VAL_W-1:0] RESET_MAX = 32'sh8000_0000;

	localparam logic [SCALED_W-1:0] Q16_HALF = 17'd32768;
	localparam logic [SCALED_W-1:0] Q16_ONE  = 17'd65536;

	typedef enum logic [1:0] {
		OP_CLEAR,
		OP_OBSERVE,
		OP_SCALE,
		OP_HALF
	} op_t;

	typedef struct packed {
		op_t                     op;
		logic [COL_W-1:0]        column;
		logic signed [VAL_W-1:0] value;
	} cmd_t;

endpackage

@@ src/cmmr_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cmmr_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

@@ src/cmmr_front.sv @@
// Input side: accepts stream items and turns them into queued commands.
// Depends on cmmr_pkg.
module cmmr_front #(
	parameter int MAX_COLUMNS = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [39:0]          s_axis_tdata,   // column[5:0], value[37:6], zero pad
	input  logic [1:0]           s_axis_tuser,   // kind[1:0]
	input  logic                 q_full,
	input  logic                 init_busy,
	output logic                 push,
	output cmmr_pkg::cmd_t       cmd
);
	import cmmr_pkg::*;

	logic [COL_W-1:0] column;
	logic             col_ok;
	logic             take;

	assign column        = s_axis_tdata[COL_W-1:0];
	assign col_ok        = 32'(column) < 32'(MAX_COLUMNS);
	assign s_axis_tready = !q_full && !init_busy;
	assign take          = s_axis_tvalid && s_axis_tready;

	always_comb begin
		cmd.column = column;
		cmd.value  = s_axis_tdata[COL_W +: VAL_W];
		cmd.op     = OP_HALF;
		push       = 1'b0;
		case (s_axis_tuser)
			KIND_CLEAR: begin
				cmd.op = OP_CLEAR;
				push   = take;
			end
			KIND_OBSERVE: begin
				cmd.op = OP_OBSERVE;
				push   = take && col_ok;
			end
			KIND_SCALE: begin
				cmd.op = col_ok ? OP_SCALE : OP_HALF;
				push   = take;
			end
			default: begin
				push = 1'b0;
			end
		endcase
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		push |-> take)
		else $error("command queued without an accepted item");
endmodule

@@ src/cmmr_fifo.sv @@
// Short command queue between the front and the back.
// Depends on cmmr_pkg for the command type.
module cmmr_fifo #(
	parameter int DEPTH = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  cmmr_pkg::cmd_t wdata,
	input  logic           pop,
	output cmmr_pkg::cmd_t rdata,
	output logic           full,
	output logic           empty
);
	import cmmr_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	cmd_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [PW:0]   count_q;

	assign full  = count_q == (PW + 1)'(DEPTH);
	assign empty = count_q == '0;
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + (PW + 1)'(push) - (PW + 1)'(pop);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("push into full queue");
	assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && empty))
		else $error("pop from empty queue");
endmodule

@@ src/cmmr_back.sv @@
// Execution side: column range store, clear sweep, scaling and divider.
// Depends on cmmr_pkg and cmmr_ram.
module cmmr_back #(
	parameter int MAX_COLUMNS = 64
) (
	input  logic           clk,
	input  logic           arst_n,
	input  cmmr_pkg::cmd_t head,
	input  logic           q_empty,
	output logic           pop,
	output logic           init_busy,
	output logic           m_axis_tvalid,
	input  logic           m_axis_tready,
	output logic [23:0]    m_axis_tdata    // scaled[16:0], zero pad
);
	import cmmr_pkg::*;

	localparam int AW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;

	typedef enum logic [2:0] {
		ST_SWEEP,
		ST_IDLE,
		ST_READ,
		ST_CHECK,
		ST_DIV,
		ST_OUT
	} state_t;

	state_t                    state_q;
	op_t                       op_q;
	logic signed [VAL_W-1:0]   val_q;
	logic [AW-1:0]             addr_q;
	logic [AW-1:0]             cnt_q;
	logic                      init_q;
	logic                      never_q;
	logic                      equal_q;
	logic signed [VAL_W:0]     diff_q;
	logic [VAL_W:0]            range_q;
	logic [VAL_W:0]            rem_q;
	logic [QUO_W-1:0]          quo_q;
	logic [3:0]                step_q;
	logic [SCALED_W-1:0]       result_q;

	logic                      ram_we;
	logic [AW-1:0]             ram_waddr;
	logic [2*VAL_W-1:0]        ram_wdata;
	logic                      ram_re;
	logic [2*VAL_W-1:0]        ram_rdata;

	logic signed [VAL_W-1:0]   lo;
	logic signed [VAL_W-1:0]   hi;
	logic signed [VAL_W:0]     diff_d;
	logic [VAL_W:0]            range_d;
	logic signed [VAL_W+1:0]   half_d;
	logic [VAL_W+1:0]          shifted;
	logic                      qbit;

	cmmr_ram #(
		.WIDTH (2 * VAL_W),
		.DEPTH (MAX_COLUMNS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (AW'(head.column)),
		.rdata (ram_rdata)
	);

	assign lo      = ram_rdata[VAL_W-1:0];
	assign hi      = ram_rdata[2*VAL_W-1:VAL_W];
	assign diff_d  = {val_q[VAL_W-1], val_q} - {lo[VAL_W-1], lo};
	assign range_d = {hi[VAL_W-1], hi} - {lo[VAL_W-1], lo};
	assign half_d  = {diff_q[VAL_W], diff_q} + (VAL_W + 2)'(Q16_HALF);
	assign shifted = {rem_q, 1'b0};
	assign qbit    = shifted >= {1'b0, range_q};

	assign pop           = (state_q == ST_IDLE) && !q_empty;
	assign ram_re        = pop;
	assign init_busy     = init_q;
	assign m_axis_tvalid = state_q == ST_OUT;
	assign m_axis_tdata  = {7'd0, result_q};

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = addr_q;
		ram_wdata = {RESET_MAX, RESET_MIN};
		if (state_q == ST_SWEEP) begin
			ram_we    = 1'b1;
			ram_waddr = cnt_q;
		end else if (state_q == ST_READ && op_q == OP_OBSERVE) begin
			ram_we    = 1'b1;
			ram_wdata = {(val_q > hi) ? val_q : hi, (val_q < lo) ? val_q : lo};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_SWEEP;
			cnt_q    <= '0;
			init_q   <= 1'b1;
			op_q     <= OP_HALF;
			val_q    <= '0;
			addr_q   <= '0;
			never_q  <= 1'b0;
			equal_q  <= 1'b0;
			diff_q   <= '0;
			range_q  <= '0;
			rem_q    <= '0;
			quo_q    <= '0;
			step_q   <= '0;
			result_q <= '0;
		end else begin
			case (state_q)
				ST_SWEEP: begin
					if (cnt_q == AW'(MAX_COLUMNS - 1)) begin
						cnt_q   <= '0;
						init_q  <= 1'b0;
						state_q <= ST_IDLE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (!q_empty) begin
						op_q   <= head.op;
						val_q  <= head.value;
						addr_q <= AW'(head.column);
						case (head.op)
							OP_CLEAR: begin
								cnt_q   <= '0;
								state_q <= ST_SWEEP;
							end
							OP_HALF: begin
								result_q <= Q16_HALF;
								state_q  <= ST_OUT;
							end
							default: begin
								state_q <= ST_READ;
							end
						endcase
					end
				end
				ST_READ: begin
					never_q <= lo > hi;
					equal_q <= lo == hi;
					diff_q  <= diff_d;
					range_q <= range_d;
					state_q <= (op_q == OP_SCALE) ? ST_CHECK : ST_IDLE;
				end
				ST_CHECK: begin
					if (never_q) begin
						result_q <= Q16_HALF;
						state_q  <= ST_OUT;
					end else if (equal_q) begin
						if (half_d <= 0) begin
							result_q <= '0;
						end else if (half_d >= (VAL_W + 2)'(Q16_ONE)) begin
							result_q <= Q16_ONE;
						end else begin
							result_q <= half_d[SCALED_W-1:0];
						end
						state_q <= ST_OUT;
					end else if (diff_q <= 0) begin
						result_q <= '0;
						state_q  <= ST_OUT;
					end else if ($unsigned(diff_q) >= range_q) begin
						result_q <= Q16_ONE;
						state_q  <= ST_OUT;
					end else begin
						rem_q   <= $unsigned(diff_q);
						quo_q   <= '0;
						step_q  <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					rem_q  <= qbit ? (VAL_W + 1)'(shifted - {1'b0, range_q})
						: shifted[VAL_W:0];
					quo_q  <= {quo_q[QUO_W-2:0], qbit};
					step_q <= step_q + 1'b1;
					if (step_q == 4'(QUO_W - 1)) begin
						result_q <= {1'b0, quo_q[QUO_W-2:0], qbit};
						state_q  <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (m_axis_tready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> result_q <= Q16_ONE)
		else $error("scaled result above 1.0");
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> (range_q != '0 && rem_q < range_q))
		else $error("divider remainder out of range");
endmodule

@@ src/column_min_max_rescaler.sv @@
// Top level of the column min-max rescaler.
// Depends on cmmr_pkg, cmmr_front, cmmr_fifo, cmmr_back (and cmmr_ram below it).
//
// Normalizes each feature column into unsigned Q1.16 from its running
// minimum and maximum. An observe item passes through the back end as a
// RAM read, then a compare and write. A scale item passes through queue
// pop with RAM read, range compare, range check, a 16-step restoring
// divider with one quotient bit per cycle, and the output state, which
// holds through any output stall; out-of-range values and degenerate
// ranges skip the divider. A clear item sweeps the range RAM one column
// per cycle. After reset the same sweep runs with s_axis_tready low. A
// four-entry command queue lets the input keep accepting while the back
// end works or a result waits.
module column_min_max_rescaler #(
	parameter int MAX_COLUMNS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,   // column[5:0], value[37:6], zero pad
	input  logic [1:0]  s_axis_tuser,   // kind[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata    // scaled[16:0], zero pad
);
	import cmmr_pkg::*;

	cmd_t push_cmd;
	cmd_t head;
	logic push;
	logic pop;
	logic q_full;
	logic q_empty;
	logic init_busy;

	cmmr_front #(
		.MAX_COLUMNS (MAX_COLUMNS)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.q_full        (q_full),
		.init_busy     (init_busy),
		.push          (push),
		.cmd           (push_cmd)
	);

	cmmr_fifo #(
		.DEPTH (4)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (push_cmd),
		.pop    (pop),
		.rdata  (head),
		.full   (q_full),
		.empty  (q_empty)
	);

	cmmr_back #(
		.MAX_COLUMNS (MAX_COLUMNS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.q_empty       (q_empty),
		.pop           (pop),
		.init_busy     (init_busy),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);
endmodule

@@ test/column_min_max_rescaler_tb.sv @@
// Self-checking testbench for column_min_max_rescaler: directed table, then random items.
// Tracks per-column ranges in its own rescale predictor; depends on cmmr_pkg and the RTL only.
`timescale 1ns / 100ps

module column_min_max_rescaler_tb;
	import cmmr_pkg::*;

	localparam int N_COLS = 64;
	localparam int N_RANDOM = 500;

	typedef struct {
		op_t                     kind;
		logic [COL_W-1:0]        column;
		logic signed [VAL_W-1:0] value;
		bit                      known;
		logic [SCALED_W-1:0]     scaled;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata = '0;
	logic [1:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;

	logic signed [VAL_W-1:0] col_lo [N_COLS];
	logic signed [VAL_W-1:0] col_hi [N_COLS];
	logic [SCALED_W-1:0]     scaled_q [$];
	logic [SCALED_W-1:0]     want;
	bit quiet = 1'b0;
	int n_items = 0;
	int n_scales = 0;
	int n_clears = 0;
	int n_results = 0;
	int n_mismatch = 0;
	int n_unexpected = 0;

	column_min_max_rescaler dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [SCALED_W-1:0] rescale(logic signed [VAL_W-1:0] v,
			logic signed [VAL_W-1:0] lo, logic signed [VAL_W-1:0] hi);
		longint d;
		longint r;
		if (lo > hi)
			return Q16_HALF;
		if (lo == hi) begin
			d = longint'(v) - longint'(lo) + 32768;
			if (d <= 0)
				return '0;
			if (d >= 65536)
				return Q16_ONE;
			return SCALED_W'(d);
		end
		d = longint'(v) - longint'(lo);
		r = longint'(hi) - longint'(lo);
		if (d <= 0)
			return '0;
		if (d >= r)
			return Q16_ONE;
		return SCALED_W'((d * 65536) / r);
	endfunction

	function automatic void clear_ranges();
		for (int i = 0; i < N_COLS; i++) begin
			col_lo[i] = RESET_MIN;
			col_hi[i] = RESET_MAX;
		end
	endfunction

	// updates the range copy and returns the expected result, if any
	function automatic bit track_item(op_t k, logic [COL_W-1:0] c,
			logic signed [VAL_W-1:0] v, output logic [SCALED_W-1:0] r);
		r = '0;
		case (k)
			OP_CLEAR: begin
				clear_ranges();
			end
			OP_OBSERVE: begin
				if (v < col_lo[c])
					col_lo[c] = v;
				if (v > col_hi[c])
					col_hi[c] = v;
			end
			OP_SCALE: begin
				r = rescale(v, col_lo[c], col_hi[c]);
				return 1'b1;
			end
			default: ;
		endcase
		return 1'b0;
	endfunction

	task automatic send_item(op_t k, logic [COL_W-1:0] c, logic signed [VAL_W-1:0] v,
			bit known, logic [SCALED_W-1:0] typed);
		int gap;
		logic [SCALED_W-1:0] r;
		gap = (!quiet && $urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0;
		@(negedge clk);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {2'b00, v, c};
		s_axis_tuser  <= k;
		do @(posedge clk); while (!s_axis_tready);
		if (track_item(k, c, v, r)) begin
			scaled_q.push_back(known ? typed : r);
			n_scales++;
		end
		if (k == OP_CLEAR)
			n_clears++;
		if (k != OP_HALF)
			n_items++;
	endtask

	// result sink with random stall bursts
	initial begin
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!quiet && $urandom_range(0, 5) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 3)) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			n_results++;
			if (scaled_q.size() == 0) begin
				n_unexpected++;
				if (n_unexpected + n_mismatch <= 10)
					$display("%0t: unexpected result scaled=%0d", $realtime, m_axis_tdata[16:0]);
			end else begin
				want = scaled_q.pop_front();
				if (m_axis_tdata[16:0] !== want) begin
					n_mismatch++;
					if (n_unexpected + n_mismatch <= 10)
						$display("%0t: scaled mismatch: expected %0d, got %0d",
							$realtime, want, m_axis_tdata[16:0]);
				end
			end
		end
	end

	initial begin
		#5ms;
		$display("timeout with %0d results outstanding", scaled_q.size());
		$display("** column_min_max_rescaler: FAILED **");
		$finish;
	end

	initial begin
		dir_row_t dir_table[$];
		op_t k;
		logic [COL_W-1:0] c;
		logic signed [VAL_W-1:0] v;
		int pick;
		int mode;

		clear_ranges();
		dir_table.push_back('{OP_SCALE,   6'd0,  32'sd0,           1'b1, Q16_HALF});
		dir_table.push_back('{OP_HALF,    6'd0,  32'sd0,           1'b0, '0});
		dir_table.push_back('{OP_OBSERVE, 6'd0,  RESET_MIN,        1'b0, '0});
		dir_table.push_back('{OP_SCALE,   6'd0,  RESET_MIN,        1'b1, Q16_HALF});
		dir_table.push_back('{OP_SCALE,   6'd0,  RESET_MAX,        1'b1, '0});
		dir_table.push_back('{OP_OBSERVE, 6'd0,  RESET_MAX,        1'b0, '0});
		dir_table.push_back('{OP_SCALE,   6'd0,  32'sd0,           1'b0, '0});
		dir_table.push_back('{OP_SCALE,   6'd0,  RESET_MIN,        1'b1, Q16_ONE});
		dir_table.push_back('{OP_SCALE,   6'd0,  RESET_MAX,        1'b1, '0});
		dir_table.push_back('{OP_OBSERVE, 6'd63, 32'sd100,         1'b0, '0});
		dir_table.push_back('{OP_SCALE,   6'd63, 32'sd100,         1'b1, Q16_HALF});
		dir_table.push_back('{OP_SCALE,   6'd63, 32'sd32868,       1'b1, Q16_ONE});
		dir_table.push_back('{OP_SCALE,   6'd63, -32'sd32668,      1'b1, '0});
		dir_table.push_back('{OP_SCALE,   6'd63, 32'sd101,         1'b0, '0});
		dir_table.push_back('{OP_OBSERVE, 6'd63, 32'sd196708,      1'b0, '0});
		dir_table.push_back('{OP_SCALE,   6'd63, 32'sd65636,       1'b0, '0});
		dir_table.push_back('{OP_SCALE,   6'd63, 32'sd300000,      1'b1, Q16_ONE});
		dir_table.push_back('{OP_CLEAR,   6'd0,  32'sd0,           1'b0, '0});
		dir_table.push_back('{OP_SCALE,   6'd63, 32'sd100,         1'b1, Q16_HALF});
		dir_table.push_back('{OP_SCALE,   6'd0,  RESET_MAX,        1'b1, Q16_HALF});
		// a first observe on a cleared column must set both ends
		dir_table.push_back('{OP_OBSERVE, 6'd7,  32'sd42,          1'b0, '0});
		dir_table.push_back('{OP_SCALE,   6'd7,  32'sd42,          1'b1, Q16_HALF});
		dir_table.push_back('{OP_OBSERVE, 6'd5,  -32'sd5,          1'b0, '0});
		dir_table.push_back('{OP_OBSERVE, 6'd5,  32'sd7,           1'b0, '0});
		dir_table.push_back('{OP_SCALE,   6'd5,  -32'sd5,          1'b1, '0});
		dir_table.push_back('{OP_SCALE,   6'd5,  32'sd7,           1'b1, Q16_ONE});
		dir_table.push_back('{OP_SCALE,   6'd5,  32'sd1,           1'b0, '0});

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (dir_table[i])
			send_item(dir_table[i].kind, dir_table[i].column, dir_table[i].value,
				dir_table[i].known, dir_table[i].scaled);

		while (n_items < dir_table.size() + N_RANDOM) begin
			quiet = (n_items > dir_table.size() + N_RANDOM - 80);
			pick = $urandom_range(0, 99);
			if (pick < 2)
				k = OP_CLEAR;
			else if (pick < 4)
				k = OP_HALF;
			else if (pick < 48)
				k = OP_OBSERVE;
			else
				k = OP_SCALE;
			c = ($urandom_range(0, 3) == 0) ? COL_W'($urandom_range(0, 63))
				: COL_W'($urandom_range(0, 7));
			mode = $urandom_range(0, 99);
			if (mode < 5)
				v = $urandom();
			else if (mode < 8)
				v = $urandom_range(0, 1) ? RESET_MIN : RESET_MAX;
			else if (k == OP_SCALE && mode < 40 && col_lo[c] <= col_hi[c])
				v = col_lo[c] + VAL_W'($urandom_range(0, 80000)) - 32'sd40000;
			else if (k == OP_SCALE && mode < 70 && col_lo[c] <= col_hi[c])
				v = col_hi[c] - VAL_W'($urandom_range(0, 80000)) + 32'sd20000;
			else
				v = VAL_W'($urandom_range(0, 400000)) - 32'sd200000;
			send_item(k, c, v, 1'b0, '0);
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b0;

		while (scaled_q.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);

		$display("%0d items sent (%0d scale, %0d clear), %0d results checked",
			n_items, n_scales, n_clears, n_results);
		$display("%0d mismatches, %0d unexpected results", n_mismatch, n_unexpected);
		if (n_mismatch == 0 && n_unexpected == 0 && scaled_q.size() == 0)
			$display("** column_min_max_rescaler: PASSED **");
		else
			$display("** column_min_max_rescaler: FAILED **");
		$finish;
	end

endmodule

@@ sim.f @@
src/cmmr_pkg.sv
src/cmmr_ram.sv
src/cmmr_front.sv
src/cmmr_fifo.sv
src/cmmr_back.sv
src/column_min_max_rescaler.sv
test/column_min_max_rescaler_tb.sv
